>>> rtl/core/nmea_rmc_time_extract_top_defines.svh
// Assertion macros for the RMC time extractor.
`ifndef NMEA_RMC_TIME_EXTRACT_TOP_DEFINES_SVH
`define NMEA_RMC_TIME_EXTRACT_TOP_DEFINES_SVH

`ifndef SYNTH
// implication checked on every clock edge outside reset
`define NRTE_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("nrte: property failed");
// condition that must never hold outside reset
`define NRTE_NEVER(label, clk, rstn, expr) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("nrte: forbidden condition seen");
`else
`define NRTE_ASSERT(label, clk, rstn, prop)
`define NRTE_NEVER(label, clk, rstn, expr)
`endif

`endif

>>> rtl/core/nrte_pkg.sv
// Shared types, constants and the digit-pair conversion for the RMC time extractor.
`default_nettype none

package nrte_pkg;

  // packet geometry
  localparam int PACKET_BYTES_DEF = 512;
  localparam int POS_W            = 10;
  localparam int SCAN_BASE        = 206;
  localparam int FIELD_LEN        = 6;
  localparam int VAL_W            = 13;

  // characters of interest
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_V     = 8'h56;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  // comma numbers that open fields or checks
  localparam logic [3:0] COMMA_TIME = 4'd1;
  localparam logic [3:0] COMMA_NAV  = 4'd2;
  localparam logic [3:0] COMMA_DATE = 4'd9;

  // range limits
  localparam logic signed [VAL_W-1:0] YEAR_MAX  = 13'sd99;
  localparam logic signed [VAL_W-1:0] MONTH_MAX = 13'sd12;
  localparam logic signed [VAL_W-1:0] DAY_MAX   = 13'sd31;
  localparam logic signed [VAL_W-1:0] HOUR_MAX  = 13'sd23;
  localparam logic signed [VAL_W-1:0] MIN_MAX   = 13'sd59;
  localparam logic signed [VAL_W-1:0] SEC_EDGE  = 13'sd57;
  localparam logic signed [VAL_W-1:0] VAL_ONE   = 13'sd1;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_LENGTH   = 3'd1,
    ST_NAV      = 3'd2,
    ST_MISSING  = 3'd3,
    ST_INVALID  = 3'd4,
    ST_BOUNDARY = 3'd5
  } status_t;

  // six captured characters, first one at index 0
  typedef logic [FIELD_LEN-1:0][7:0] field_t;

  // packet-level flags handed to the decoder
  typedef struct packed {
    logic len_ok;
    logic nav_warning;
    logic time_complete;
    logic date_complete;
  } flags_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] second_value;
    logic signed [VAL_W-1:0] minute_value;
    logic signed [VAL_W-1:0] hour_value;
    logic signed [VAL_W-1:0] day_value;
    logic signed [VAL_W-1:0] month_value;
    logic signed [VAL_W-1:0] year_value;
    status_t                 status;
  } result_t;

  // (hi - '0') * 10 + (lo - '0'), no digit check
  function automatic logic signed [VAL_W-1:0] pair_value(logic [7:0] hi, logic [7:0] lo);
    logic signed [VAL_W-1:0] a;
    logic signed [VAL_W-1:0] b;
    logic signed [VAL_W-1:0] zero;
    zero = $signed({5'b0, CHAR_ZERO});
    a    = $signed({5'b0, hi}) - zero;
    b    = $signed({5'b0, lo}) - zero;
    return (a <<< 3) + (a <<< 1) + b;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/nrte_decode.sv
// Final-byte decoder: digit-pair conversion, range checks and status priority.
`default_nettype none

module nrte_decode (
  input  wire nrte_pkg::field_t  time_chars,
  input  wire nrte_pkg::field_t  date_chars,
  input  wire nrte_pkg::flags_t  flags,
  output nrte_pkg::result_t      result
);

  logic signed [nrte_pkg::VAL_W-1:0] yr;
  logic signed [nrte_pkg::VAL_W-1:0] mo;
  logic signed [nrte_pkg::VAL_W-1:0] dy;
  logic signed [nrte_pkg::VAL_W-1:0] hr;
  logic signed [nrte_pkg::VAL_W-1:0] mi;
  logic signed [nrte_pkg::VAL_W-1:0] se;
  logic                              out_of_range;
  logic                              boundary;

  // conversions
  assign yr = nrte_pkg::pair_value(date_chars[4], date_chars[5]);
  assign mo = nrte_pkg::pair_value(date_chars[2], date_chars[3]);
  assign dy = nrte_pkg::pair_value(date_chars[0], date_chars[1]);
  assign hr = nrte_pkg::pair_value(time_chars[0], time_chars[1]);
  assign mi = nrte_pkg::pair_value(time_chars[2], time_chars[3]);
  assign se = nrte_pkg::pair_value(time_chars[4], time_chars[5]);

  // range checks; negative year, hour, minute and second pass
  assign out_of_range = (yr > nrte_pkg::YEAR_MAX) ||
                        (mo > nrte_pkg::MONTH_MAX) || (mo < nrte_pkg::VAL_ONE) ||
                        (dy > nrte_pkg::DAY_MAX) || (dy < nrte_pkg::VAL_ONE) ||
                        (hr > nrte_pkg::HOUR_MAX) ||
                        (mi > nrte_pkg::MIN_MAX) || (se > nrte_pkg::MIN_MAX);
  assign boundary     = (mi == nrte_pkg::MIN_MAX) && (se >= nrte_pkg::SEC_EDGE);

  // status priority, values zeroed on the early failures
  always_comb begin
    result = '0;
    if (!flags.len_ok) begin
      result.status = nrte_pkg::ST_LENGTH;
    end else if (flags.nav_warning) begin
      result.status = nrte_pkg::ST_NAV;
    end else if (!flags.time_complete || !flags.date_complete) begin
      result.status = nrte_pkg::ST_MISSING;
    end else begin
      result.year_value   = yr;
      result.month_value  = mo;
      result.day_value    = dy;
      result.hour_value   = hr;
      result.minute_value = mi;
      result.second_value = se;
      if (out_of_range) begin
        result.status = nrte_pkg::ST_INVALID;
      end else if (boundary) begin
        result.status = nrte_pkg::ST_BOUNDARY;
      end else begin
        result.status = nrte_pkg::ST_OK;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/nmea_rmc_time_extract_top.sv
// RMC sentence time/date extractor: stream in packet bytes, one result per packet.
//
// Input stream: one packet byte per transfer on in_tdata, in_tlast on the final byte.
// Output stream: one result per packet (status plus six converted fields), presented
// in the cycle after the final byte is transferred. No result for other bytes.
// Throughput: one byte per cycle while in_tready is high; each byte updates the scan state registers
// in the cycle it is transferred, and the final byte also loads the result
// register through the decoder in that same cycle.
// Stall: the result register holds while out_tready is low; in_tready then drops
// until the result is taken, and rises again in the cycle it is taken.
// Reset (rst_n low, synchronous): clears the byte count, comma scan, field flags
// and the output valid; captured field characters are not cleared.
// After each final byte the packet state returns to its reset values.
`default_nettype none

module nmea_rmc_time_extract_top #(
  parameter int PACKET_BYTES = nrte_pkg::PACKET_BYTES_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  // input stream
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] rx_byte
  input  wire         in_tlast,   // last_byte
  // result stream
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [87:0] out_tdata   // [2:0] status, [15:3] year_value, [28:16] month_value,
                                  // [41:29] day_value, [54:42] hour_value,
                                  // [67:55] minute_value, [80:68] second_value, rest zero
);

  `include "nmea_rmc_time_extract_top_defines.svh"

  localparam logic [nrte_pkg::POS_W-1:0] POS_MAX   = '1;
  localparam logic [nrte_pkg::POS_W-1:0] POS_ONE   = nrte_pkg::POS_W'(1);
  localparam logic [nrte_pkg::POS_W-1:0] SCAN_LO   = nrte_pkg::POS_W'(nrte_pkg::SCAN_BASE);
  localparam logic [nrte_pkg::POS_W-1:0] SCAN_HI   = nrte_pkg::POS_W'(PACKET_BYTES);
  localparam logic [nrte_pkg::POS_W:0]   LEN_WANT  = (nrte_pkg::POS_W + 1)'(PACKET_BYTES);
  localparam logic [2:0]                 FLEN      = 3'(nrte_pkg::FIELD_LEN);

  // packet state
  logic [nrte_pkg::POS_W-1:0] byte_pos_r,      byte_pos_nxt;
  logic [3:0]                 comma_count_r,   comma_count_nxt;
  logic                       scan_stopped_r,  scan_stopped_nxt;
  logic                       nav_warning_r,   nav_warning_nxt;
  logic                       check_next_r,    check_next_nxt;
  logic [2:0]                 time_left_r,     time_left_nxt;
  logic [2:0]                 date_left_r,     date_left_nxt;
  logic                       time_complete_r, time_complete_nxt;
  logic                       date_complete_r, date_complete_nxt;
  nrte_pkg::field_t           time_chars_r,    time_chars_nxt;
  nrte_pkg::field_t           date_chars_r,    date_chars_nxt;

  // result register
  logic                       out_valid_r,     out_valid_nxt;
  nrte_pkg::result_t          result_r;
  nrte_pkg::result_t          dec_result;
  nrte_pkg::flags_t           dec_flags;

  logic                       in_fire;
  logic                       in_final;
  logic [7:0]                 rx_byte;
  logic                       in_scan;

  assign rx_byte   = in_tdata;
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign in_final  = in_fire && in_tlast;
  assign in_scan   = !scan_stopped_r && (byte_pos_r > SCAN_LO) && (byte_pos_r < SCAN_HI);

  // per-byte scan, capture and warning logic
  always_comb begin
    byte_pos_nxt      = byte_pos_r;
    comma_count_nxt   = comma_count_r;
    scan_stopped_nxt  = scan_stopped_r;
    nav_warning_nxt   = nav_warning_r;
    check_next_nxt    = check_next_r;
    time_left_nxt     = time_left_r;
    date_left_nxt     = date_left_r;
    time_complete_nxt = time_complete_r;
    date_complete_nxt = date_complete_r;
    time_chars_nxt    = time_chars_r;
    date_chars_nxt    = date_chars_r;

    if (in_fire) begin
      // byte following the second comma
      if (check_next_r) begin
        if (rx_byte == nrte_pkg::CHAR_V) begin
          nav_warning_nxt = 1'b1;
        end
        check_next_nxt = 1'b0;
      end

      // field capture, shifting towards index 0
      if (time_left_r != 3'd0) begin
        time_chars_nxt = {rx_byte, time_chars_r[nrte_pkg::FIELD_LEN-1:1]};
        time_left_nxt  = time_left_r - 3'd1;
        if (time_left_r == 3'd1) begin
          time_complete_nxt = 1'b1;
        end
      end
      if (date_left_r != 3'd0) begin
        date_chars_nxt = {rx_byte, date_chars_r[nrte_pkg::FIELD_LEN-1:1]};
        date_left_nxt  = date_left_r - 3'd1;
        if (date_left_r == 3'd1) begin
          date_complete_nxt = 1'b1;
        end
      end

      // comma scan
      if (in_scan) begin
        if (rx_byte == nrte_pkg::CHAR_STAR) begin
          scan_stopped_nxt = 1'b1;
        end else if (rx_byte == nrte_pkg::CHAR_COMMA) begin
          comma_count_nxt = comma_count_r + 4'd1;
          if (comma_count_nxt == nrte_pkg::COMMA_TIME) begin
            time_left_nxt = FLEN;
          end else if (comma_count_nxt == nrte_pkg::COMMA_NAV) begin
            check_next_nxt = 1'b1;
          end else if (comma_count_nxt == nrte_pkg::COMMA_DATE) begin
            date_left_nxt    = FLEN;
            scan_stopped_nxt = 1'b1;
          end
        end
      end

      if (byte_pos_r != POS_MAX) begin
        byte_pos_nxt = byte_pos_r + POS_ONE;
      end
    end
  end

  // decoder sees the state as updated by the final byte
  assign dec_flags.len_ok        = ({1'b0, byte_pos_r} + {1'b0, POS_ONE}) == LEN_WANT;
  assign dec_flags.nav_warning   = nav_warning_nxt;
  assign dec_flags.time_complete = time_complete_nxt;
  assign dec_flags.date_complete = date_complete_nxt;

  nrte_decode u_decode (
    .time_chars (time_chars_nxt),
    .date_chars (date_chars_nxt),
    .flags      (dec_flags),
    .result     (dec_result)
  );

  // output valid: set by a final byte, cleared when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_final) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state; a final byte returns the packet state to reset
  always_ff @(posedge clk) begin
    if (!rst_n || in_final) begin
      byte_pos_r      <= '0;
      comma_count_r   <= '0;
      scan_stopped_r  <= 1'b0;
      nav_warning_r   <= 1'b0;
      check_next_r    <= 1'b0;
      time_left_r     <= '0;
      date_left_r     <= '0;
      time_complete_r <= 1'b0;
      date_complete_r <= 1'b0;
    end else begin
      byte_pos_r      <= byte_pos_nxt;
      comma_count_r   <= comma_count_nxt;
      scan_stopped_r  <= scan_stopped_nxt;
      nav_warning_r   <= nav_warning_nxt;
      check_next_r    <= check_next_nxt;
      time_left_r     <= time_left_nxt;
      date_left_r     <= date_left_nxt;
      time_complete_r <= time_complete_nxt;
      date_complete_r <= date_complete_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    time_chars_r <= time_chars_nxt;
    date_chars_r <= date_chars_nxt;
    if (in_final) begin
      result_r <= dec_result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, result_r};

  // checks
  `NRTE_ASSERT(a_result_from_final, clk, rst_n,
               $rose(out_valid_r) |-> $past(in_final))
  `NRTE_ASSERT(a_state_cleared, clk, rst_n,
               $past(in_final) |-> (byte_pos_r == '0 && comma_count_r == '0))
  `NRTE_NEVER(a_comma_limit, clk, rst_n, comma_count_r > nrte_pkg::COMMA_DATE)
  `NRTE_NEVER(a_time_done_excl, clk, rst_n, time_complete_r && (time_left_r != 3'd0))

endmodule

`default_nettype wire
